[hw/rtl/sbe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

  // Tag stack
  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned STK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Token queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Longest expansion of one token is nine characters
  localparam int unsigned SUB_W = 4;

  localparam logic [15:0] CH_LT    = 16'h003C;
  localparam logic [15:0] CH_GT    = 16'h003E;
  localparam logic [15:0] CH_AMP   = 16'h0026;
  localparam logic [15:0] CH_QUOT  = 16'h0022;
  localparam logic [15:0] CH_SLASH = 16'h002F;
  localparam logic [15:0] CH_B     = 16'h0062;
  localparam logic [15:0] CH_I     = 16'h0069;
  localparam logic [15:0] CH_U     = 16'h0075;

  localparam logic [1:0] CODE_B = 2'd0;
  localparam logic [1:0] CODE_I = 2'd1;
  localparam logic [1:0] CODE_U = 2'd2;

  typedef struct packed {
    logic [15:0] in_char;
    logic        is_last;
  } in_t;

  typedef struct packed {
    logic [15:0] out_char;
    logic        char_valid;
    logic        run_end;
    logic        message_end;
    logic        overflow;
  } out_t;

  typedef enum logic [2:0] {
    TK_TEXT,
    TK_OPEN,
    TK_OPEN_OV,
    TK_CLOSE,
    TK_END
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [15:0] ch;
    logic        last;
  } tok_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_SCAN,
    FS_FLUSH,
    FS_END
  } front_state_e;

  function automatic logic is_letter(input logic [15:0] c);
    return (c == CH_B) || (c == CH_I) || (c == CH_U);
  endfunction

  function automatic logic [1:0] letter_code(input logic [15:0] c);
    logic [1:0] r;
    r = CODE_U;
    if (c == CH_B) r = CODE_B;
    else if (c == CH_I) r = CODE_I;
    return r;
  endfunction

  function automatic logic [15:0] code_char(input logic [1:0] code);
    logic [15:0] r;
    r = CH_U;
    if (code == CODE_B) r = CH_B;
    else if (code == CODE_I) r = CH_I;
    return r;
  endfunction

  // Character idx of the escaped form of c
  function automatic logic [15:0] esc_char(input logic [15:0] c, input logic [SUB_W-1:0] idx);
    logic [15:0] r;
    r = c;
    if (c == CH_LT) begin
      unique case (idx)
        4'd0:    r = CH_AMP;
        4'd1:    r = 16'h006C;
        4'd2:    r = 16'h0074;
        default: r = 16'h003B;
      endcase
    end else if (c == CH_GT) begin
      unique case (idx)
        4'd0:    r = CH_AMP;
        4'd1:    r = 16'h0067;
        4'd2:    r = 16'h0074;
        default: r = 16'h003B;
      endcase
    end else if (c == CH_AMP) begin
      unique case (idx)
        4'd0:    r = CH_AMP;
        4'd1:    r = 16'h0061;
        4'd2:    r = 16'h006D;
        4'd3:    r = 16'h0070;
        default: r = 16'h003B;
      endcase
    end else if (c == CH_QUOT) begin
      unique case (idx)
        4'd0:    r = CH_AMP;
        4'd1:    r = 16'h0071;
        4'd2:    r = 16'h0075;
        4'd3:    r = 16'h006F;
        4'd4:    r = 16'h0074;
        default: r = 16'h003B;
      endcase
    end
    return r;
  endfunction

  function automatic logic [SUB_W-1:0] esc_len(input logic [15:0] c);
    logic [SUB_W-1:0] r;
    r = 4'd1;
    if (c == CH_LT || c == CH_GT) r = 4'd4;
    else if (c == CH_AMP) r = 4'd5;
    else if (c == CH_QUOT) r = 4'd6;
    return r;
  endfunction

  function automatic logic [SUB_W-1:0] tok_len(input tok_t t);
    logic [SUB_W-1:0] r;
    unique case (t.kind)
      TK_TEXT:    r = esc_len(t.ch);
      TK_OPEN:    r = 4'd3;
      TK_OPEN_OV: r = 4'd9;
      TK_CLOSE:   r = 4'd4;
      default:    r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] tok_char(input tok_t t, input logic [SUB_W-1:0] idx);
    logic [15:0] r;
    r = t.ch;
    unique case (t.kind)
      TK_TEXT: r = esc_char(t.ch, idx);
      TK_OPEN: begin
        unique case (idx)
          4'd0:    r = CH_LT;
          4'd1:    r = t.ch;
          default: r = CH_GT;
        endcase
      end
      TK_OPEN_OV: begin
        if (idx < 4'd4) r = esc_char(CH_LT, idx);
        else if (idx == 4'd4) r = t.ch;
        else r = esc_char(CH_GT, idx - 4'd5);
      end
      TK_CLOSE: begin
        unique case (idx)
          4'd0:    r = CH_LT;
          4'd1:    r = CH_SLASH;
          4'd2:    r = t.ch;
          default: r = CH_GT;
        endcase
      end
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/style_tag_balancer_escaper.sv]
`timescale 1ns / 1ps
`default_nettype none

// Style tag balancer and escaper. Takes a message one 16-bit character per request,
// is_last on the final one. Opening tags <b> <i> <u> pass through and are pushed on
// an eight-entry tag stack; any closing tag </b> </i> </u> is replaced by the closer
// of the tag on top of the stack (dropped when the stack is empty). Other characters
// pass through with < > & and the double quote turned into entities. Up to three
// characters that may still start a tag are held back until the next request. At
// the end of a message the held characters are escaped and sent, then all open tags
// are closed; a message that produced nothing ends with one result carrying
// char_valid = 0. An opening tag met with a full stack is sent as &lt;X&gt; with
// overflow set on its nine characters. run_end marks the last result of each input
// request, message_end the last of the message.
// Flow: the front scanner emits one token (tag, closer or plain character) at a
// time, or holds back a partial tag, and then closes out the request before it
// takes the next character; after a last character it closes each open tag in
// turn and ends the message. The back end sends one output character per cycle
// while the output is not stalled, so escapes (up to six characters) and
// overflowed tags (nine) set the sustained rate; a four-entry token queue lets the
// scanner run ahead of the output side.

module style_tag_balancer_escaper (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  sbe_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output sbe_pkg::out_t out_data_o
);
  import sbe_pkg::*;

  // Front to queue
  logic push;
  tok_t push_tok;
  // Queue to back
  tok_t head;
  logic pop;
  logic q_full;
  logic q_empty;

  // Scanner: lookahead window, tag stack, token generation
  sbe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_tok_o (push_tok),
    .q_full_i   (q_full)
  );

  // Token queue decouples scanning from character output
  sbe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // Expander: one output character per cycle unless stalled, run/message end tagging
  sbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[hw/rtl/sbe_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbe_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  sbe_pkg::in_t      in_data_i,
  output logic              push_o,
  output sbe_pkg::tok_t     push_tok_o,
  input  wire logic         q_full_i
);
  import sbe_pkg::*;

  front_state_e state_q, state_d;
  logic [15:0]  win_q [4];
  logic [15:0]  win_d [4];
  logic [2:0]   rem_q, rem_d;
  logic         last_q, last_d;
  logic [15:0]  la_q [3];
  logic [15:0]  la_d [3];
  logic [1:0]   la_cnt_q, la_cnt_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic [1:0]   stk_q [STACK_DEPTH];
  logic [1:0]   stk_d [STACK_DEPTH];

  logic             accept_ok, accept;
  logic             is_open, is_close, may_tag, stop;
  logic [2:0]       consume, rem_next;
  logic [LVL_W-1:0] top;
  logic             stk_full;

  assign top      = lvl_q - LVL_W'(1);
  assign stk_full = (lvl_q >= LVL_W'(STACK_DEPTH));

  always_comb begin
    is_open  = (rem_q >= 3'd3) && (win_q[0] == CH_LT) && (win_q[2] == CH_GT) &&
               is_letter(win_q[1]);
    is_close = (rem_q == 3'd4) && (win_q[0] == CH_LT) && (win_q[1] == CH_SLASH) &&
               is_letter(win_q[2]) && (win_q[3] == CH_GT);
    unique case (rem_q)
      3'd1:    may_tag = (win_q[0] == CH_LT);
      3'd2:    may_tag = (win_q[0] == CH_LT) &&
                         ((win_q[1] == CH_SLASH) || is_letter(win_q[1]));
      3'd3:    may_tag = (win_q[0] == CH_LT) && (win_q[1] == CH_SLASH) &&
                         is_letter(win_q[2]);
      default: may_tag = 1'b0;
    endcase
  end

  assign accept_ok  = (state_q == FS_IDLE) || ((state_q == FS_END) && !q_full_i);
  assign in_stall_o = !accept_ok;
  assign accept     = in_valid_i && accept_ok;

  always_comb begin
    state_d    = state_q;
    win_d      = win_q;
    rem_d      = rem_q;
    last_d     = last_q;
    la_d       = la_q;
    la_cnt_d   = la_cnt_q;
    lvl_d      = lvl_q;
    stk_d      = stk_q;
    push_o     = 1'b0;
    push_tok_o = '{kind: TK_TEXT, ch: win_q[0], last: last_q};
    consume    = 3'd0;
    stop       = 1'b0;
    rem_next   = rem_q;

    unique case (state_q)
      FS_IDLE: ;
      FS_SCAN: begin
        if (!q_full_i) begin
          priority if (is_open) begin
            push_o          = 1'b1;
            push_tok_o.kind = stk_full ? TK_OPEN_OV : TK_OPEN;
            push_tok_o.ch   = win_q[1];
            if (!stk_full) begin
              stk_d[lvl_q[STK_IDX_W-1:0]] = letter_code(win_q[1]);
              lvl_d = lvl_q + LVL_W'(1);
            end
            consume = 3'd3;
          end else if (is_close) begin
            consume = 3'd4;
            if (lvl_q != '0) begin
              push_o          = 1'b1;
              push_tok_o.kind = TK_CLOSE;
              push_tok_o.ch   = code_char(stk_q[top[STK_IDX_W-1:0]]);
              lvl_d           = top;
            end
          end else if (!last_q && may_tag) begin
            stop = 1'b1;
          end else begin
            push_o  = 1'b1;
            consume = 3'd1;
          end
          rem_next = rem_q - consume;
          if (stop) begin
            // Hold the partial tag for the next item
            for (int i = 0; i < 3; i++) la_d[i] = win_q[i];
            la_cnt_d = rem_q[1:0];
            state_d  = FS_END;
          end else begin
            unique case (consume)
              3'd1: for (int j = 0; j < 3; j++) win_d[j] = win_q[j+1];
              3'd3: win_d[0] = win_q[3];
              default: ;
            endcase
            rem_d = rem_next;
            if (rem_next == 3'd0) begin
              la_cnt_d = 2'd0;
              state_d  = last_q ? FS_FLUSH : FS_END;
            end
          end
        end
      end
      FS_FLUSH: begin
        if (!q_full_i) begin
          if (lvl_q != '0) begin
            push_o          = 1'b1;
            push_tok_o.kind = TK_CLOSE;
            push_tok_o.ch   = code_char(stk_q[top[STK_IDX_W-1:0]]);
            lvl_d           = top;
          end else begin
            state_d = FS_END;
          end
        end
      end
      FS_END: begin
        if (!q_full_i) begin
          push_o          = 1'b1;
          push_tok_o.kind = TK_END;
          state_d         = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase

    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        win_d[i] = (2'(i) < la_cnt_q) ? la_q[i] : in_data_i.in_char;
      end
      win_d[3] = in_data_i.in_char;
      rem_d    = {1'b0, la_cnt_q} + 3'd1;
      last_d   = in_data_i.is_last;
      state_d  = FS_SCAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FS_IDLE;
      la_cnt_q <= 2'd0;
      lvl_q    <= '0;
      rem_q    <= 3'd0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      la_cnt_q <= la_cnt_d;
      lvl_q    <= lvl_d;
      rem_q    <= rem_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    la_q  <= la_d;
    stk_q <= stk_d;
  end

  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LVL_W'(STACK_DEPTH))
    else $error("tag stack level beyond depth");

  a_close_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && push_tok_o.kind == TK_CLOSE) |-> (lvl_q != '0))
    else $error("closer issued from empty tag stack");

endmodule

`default_nettype wire

[hw/rtl/sbe_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbe_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  sbe_pkg::tok_t  push_tok_i,
  input  wire logic      pop_i,
  output sbe_pkg::tok_t  head_o,
  output logic           full_o,
  output logic           empty_o
);
  import sbe_pkg::*;

  tok_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_tok_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + QCNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("token queue written while full");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("token queue read while empty");

endmodule

`default_nettype wire

[hw/rtl/sbe_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbe_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  sbe_pkg::tok_t  head_i,
  input  wire logic      q_empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output sbe_pkg::out_t  out_data_o
);
  import sbe_pkg::*;

  logic [SUB_W-1:0] idx_q, idx_d;
  logic             hold_valid_q, hold_valid_d;
  logic [15:0]      hold_char_q, hold_char_d;
  logic             hold_ov_q, hold_ov_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d, out_new;
  logic             out_free, out_load;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    idx_d        = idx_q;
    hold_valid_d = hold_valid_q;
    hold_char_d  = hold_char_q;
    hold_ov_d    = hold_ov_q;
    pop_o        = 1'b0;
    out_load     = 1'b0;
    out_new.out_char    = hold_char_q;
    out_new.char_valid  = 1'b1;
    out_new.run_end     = 1'b0;
    out_new.message_end = 1'b0;
    out_new.overflow    = hold_ov_q;

    if (!q_empty_i) begin
      if (head_i.kind == TK_END) begin
        if (hold_valid_q) begin
          // Held char is the last one of this item
          if (out_free) begin
            out_load            = 1'b1;
            out_new.run_end     = 1'b1;
            out_new.message_end = head_i.last;
            hold_valid_d        = 1'b0;
            pop_o               = 1'b1;
          end
        end else if (head_i.last) begin
          // Empty end marker
          if (out_free) begin
            out_load            = 1'b1;
            out_new.out_char    = 16'h0000;
            out_new.char_valid  = 1'b0;
            out_new.run_end     = 1'b1;
            out_new.message_end = 1'b1;
            out_new.overflow    = 1'b0;
            pop_o               = 1'b1;
          end
        end else begin
          pop_o = 1'b1;
        end
      end else if (!hold_valid_q || out_free) begin
        out_load     = hold_valid_q;
        hold_valid_d = 1'b1;
        hold_char_d  = tok_char(head_i, idx_q);
        hold_ov_d    = (head_i.kind == TK_OPEN_OV);
        if (idx_q == tok_len(head_i) - SUB_W'(1)) begin
          idx_d = '0;
          pop_o = 1'b1;
        end else begin
          idx_d = idx_q + SUB_W'(1);
        end
      end
    end

    out_valid_d = out_load || (out_valid_q && out_stall_i);
    out_d       = out_load ? out_new : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_char_q <= hold_char_d;
    hold_ov_q   <= hold_ov_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_msg_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.message_end) |-> out_q.run_end)
    else $error("message end without run end");

endmodule

`default_nettype wire

[tb/tag_escape_checker.sv]
`timescale 1ns / 1ps

module tag_escape_checker
  import sbe_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_stall_i,
  input  in_t       in_data_i,
  input  wire logic out_valid_i,
  input  wire logic out_stall_i,
  input  out_t      out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic [15:0] held_chars [3];
  int          held_count;
  logic [1:0]  open_tags [STACK_DEPTH];
  int          open_depth;
  out_t        step_chars[$];
  out_t        expected_chars[$];
  int          fails;

  function automatic bit is_tag_letter(input logic [15:0] c);
    return (c == CH_B) || (c == CH_I) || (c == CH_U);
  endfunction

  function automatic logic [1:0] tag_code_of(input logic [15:0] c);
    if (c == CH_B) return CODE_B;
    if (c == CH_I) return CODE_I;
    return CODE_U;
  endfunction

  // Could the r characters starting with c0 still grow into a tag?
  function automatic bit could_be_tag(input logic [15:0] c0, input logic [15:0] c1,
                                      input logic [15:0] c2, input int r);
    if (r < 1 || r > 3 || c0 != CH_LT) return 1'b0;
    if (r == 1) return 1'b1;
    if (r == 2) return (c1 == CH_SLASH) || is_tag_letter(c1);
    return (c1 == CH_SLASH) && is_tag_letter(c2);
  endfunction

  task automatic emit_char(input logic [15:0] ch, input logic ov);
    out_t r;
    r = '0;
    r.out_char   = ch;
    r.char_valid = 1'b1;
    r.overflow   = ov;
    step_chars.push_back(r);
  endtask

  task automatic emit_text(input string s, input logic ov);
    int i;
    for (i = 0; i < s.len(); i++) emit_char({8'h00, s[i]}, ov);
  endtask

  task automatic emit_escaped(input logic [15:0] c, input logic ov);
    if (c == CH_LT) emit_text("&lt;", ov);
    else if (c == CH_GT) emit_text("&gt;", ov);
    else if (c == CH_AMP) emit_text("&amp;", ov);
    else if (c == CH_QUOT) emit_text("&quot;", ov);
    else emit_char(c, ov);
  endtask

  task automatic close_top_tag();
    if (open_depth == 0) return;
    open_depth--;
    case (open_tags[open_depth])
      CODE_B:  emit_text("</b>", 1'b0);
      CODE_I:  emit_text("</i>", 1'b0);
      CODE_U:  emit_text("</u>", 1'b0);
      default: ;
    endcase
  endtask

  // Expected output characters for one accepted request
  task automatic predict_chars(input in_t req);
    logic [15:0] w [4];
    logic [15:0] c1, c2;
    int          n, pos, rem, i;
    out_t        r;
    step_chars.delete();
    for (i = 0; i < 4; i++) w[i] = '0;
    n = held_count;
    for (i = 0; i < n; i++) w[i] = held_chars[i];
    w[n] = req.in_char;
    n++;
    pos = 0;
    while (pos < n) begin
      rem = n - pos;
      if (rem >= 3 && w[pos] == CH_LT && w[pos+2] == CH_GT && is_tag_letter(w[pos+1])) begin
        if (open_depth >= STACK_DEPTH) begin
          emit_text("&lt;", 1'b1);
          emit_char(w[pos+1], 1'b1);
          emit_text("&gt;", 1'b1);
        end else begin
          open_tags[open_depth] = tag_code_of(w[pos+1]);
          open_depth++;
          emit_char(w[pos], 1'b0);
          emit_char(w[pos+1], 1'b0);
          emit_char(w[pos+2], 1'b0);
        end
        pos += 3;
        continue;
      end
      if (rem >= 4 && w[pos] == CH_LT && w[pos+1] == CH_SLASH && is_tag_letter(w[pos+2])
          && w[pos+3] == CH_GT) begin
        close_top_tag();
        pos += 4;
        continue;
      end
      c1 = (rem > 1) ? w[pos+1] : 16'h0000;
      c2 = (rem > 2) ? w[pos+2] : 16'h0000;
      if (!req.is_last && could_be_tag(w[pos], c1, c2, rem)) break;
      emit_escaped(w[pos], 1'b0);
      pos++;
    end
    held_count = n - pos;
    for (i = 0; i < held_count; i++) held_chars[i] = w[pos+i];
    if (req.is_last) begin
      held_count = 0;
      while (open_depth > 0) close_top_tag();
      if (step_chars.size() == 0) step_chars.push_back('0);
      r = step_chars[step_chars.size()-1];
      r.message_end = 1'b1;
      step_chars[step_chars.size()-1] = r;
    end
    if (step_chars.size() > 0) begin
      r = step_chars[step_chars.size()-1];
      r.run_end = 1'b1;
      step_chars[step_chars.size()-1] = r;
    end
    foreach (step_chars[i]) expected_chars.push_back(step_chars[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      held_count = 0;
      open_depth = 0;
      expected_chars.delete();
      fails = 0;
    end else begin
      // inputs first: a result never precedes its request
      if (in_valid_i && !in_stall_i) predict_chars(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          if (fails < 10)
            $display("unexpected output: char %h valid %b run_end %b msg_end %b ov %b",
                     out_data_i.out_char, out_data_i.char_valid, out_data_i.run_end,
                     out_data_i.message_end, out_data_i.overflow);
          fails++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data_i.out_char !== want.out_char ||
              out_data_i.char_valid !== want.char_valid ||
              out_data_i.run_end !== want.run_end ||
              out_data_i.message_end !== want.message_end ||
              out_data_i.overflow !== want.overflow) begin
            if (fails < 10)
              $display("mismatch: got %h/%b/%b/%b/%b want %h/%b/%b/%b/%b",
                       out_data_i.out_char, out_data_i.char_valid, out_data_i.run_end,
                       out_data_i.message_end, out_data_i.overflow,
                       want.out_char, want.char_valid, want.run_end,
                       want.message_end, want.overflow);
            fails++;
          end
        end
      end
    end
    fail_count_o = fails;
    pending_o    = expected_chars.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import sbe_pkg::*;

  // Guard: every request with a worst-case flush, every output character
  // waiting out the longest stall, taken several times over.
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_REQS  = 400;
  // Margin for the final tag flush, which closes each open tag, and the queue drain
  localparam int DRAIN_CYCLES = 60;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int fail_count;
  int pending;
  int cycles    = 0;
  int stall_run = 0;
  bit calm      = 1'b0;     // message sent back to back, no input gaps

  logic [15:0] msg[$];      // characters of the message being built

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  style_tag_balancer_escaper u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  tag_escape_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Idle lengths: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // Output backpressure: alternate free runs and stalls; free runs are
  // sometimes long so that stretches without stalls occur as well.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      if (out_stall) begin
        out_stall <= 1'b0;
        stall_run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120)
                                                : $urandom_range(0, 8);
      end else begin
        out_stall <= 1'b1;
        stall_run = idle_len();
      end
    end else begin
      stall_run--;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Drive one request at a falling edge, hold it until accepted.
  // Valid stays high into the next request when there is no gap.
  task automatic send_req(input in_t req);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit ends_msg);
    int i;
    for (i = 0; i < s.len(); i++)
      send_req('{in_char: {8'h00, s[i]}, is_last: ends_msg && (i == s.len() - 1)});
  endtask

  function automatic logic [15:0] any_letter();
    case ($urandom_range(0, 2))
      0:       return CH_B;
      1:       return CH_I;
      default: return CH_U;
    endcase
  endfunction

  function automatic logic [15:0] any_special();
    case ($urandom_range(0, 4))
      0:       return CH_LT;
      1:       return CH_GT;
      2:       return CH_AMP;
      3:       return CH_QUOT;
      default: return CH_SLASH;
    endcase
  endfunction

  // Append one token: well-formed tags dominate, plus plain text,
  // characters needing escapes and tags that break off midway.
  task automatic add_token(input bit want_open);
    int          pick;
    logic [15:0] l;
    logic [15:0] x;
    l    = any_letter();
    x    = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535)) : any_special();
    pick = $urandom_range(0, 99);
    if (want_open || pick < 22) begin
      msg.push_back(CH_LT); msg.push_back(l); msg.push_back(CH_GT);
    end else if (pick < 40) begin
      msg.push_back(CH_LT); msg.push_back(CH_SLASH); msg.push_back(l); msg.push_back(CH_GT);
    end else if (pick < 52) begin
      msg.push_back(any_special());
    end else if (pick < 72) begin
      msg.push_back(16'($urandom_range(0, 65535)));
    end else if (pick < 80) begin
      msg.push_back(($urandom_range(0, 1) == 0) ? l : CH_SLASH);
    end else begin
      case ($urandom_range(0, 3))
        0: begin msg.push_back(CH_LT); msg.push_back(l); msg.push_back(x); end
        1: begin
          msg.push_back(CH_LT); msg.push_back(CH_SLASH); msg.push_back(l); msg.push_back(x);
        end
        2: begin msg.push_back(CH_LT); msg.push_back(x); msg.push_back(CH_GT); end
        default: begin msg.push_back(CH_LT); msg.push_back(CH_SLASH); msg.push_back(x); end
      endcase
    end
  endtask

  initial begin
    int kind;
    int random_sent;
    random_sent = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // closer on an empty stack is dropped; message with no output at all
    send_text("</u>", 1'b1);
    // nesting, mismatched closer, escapes, extreme code units, close-out at end
    send_text("<i><b></u>&\"", 1'b0);
    send_req('{in_char: 16'hFFFF, is_last: 1'b0});
    send_req('{in_char: 16'h0000, is_last: 1'b1});
    // partial tag held at the end is flushed escaped
    send_text("x</", 1'b1);
    send_text(">", 1'b1);

    while (random_sent < RANDOM_REQS) begin
      msg.delete();
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        // enough opens to fill the stack and overflow it
        repeat ($urandom_range(9, 11)) add_token(1'b1);
        repeat ($urandom_range(0, 3)) add_token(1'b0);
      end else if (kind < 25) begin
        add_token(1'b0);
      end else begin
        repeat ($urandom_range(2, 12)) add_token(1'b0);
      end
      calm = ($urandom_range(0, 3) == 0);
      foreach (msg[i]) send_req('{in_char: msg[i], is_last: (i == msg.size() - 1)});
      random_sent += msg.size();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
